// ----- rtl/frgi_pkg.sv -----
// Shared types, sizes and constants of the frame rotation engine.
`default_nettype none

package frgi_pkg;

    localparam int MAX_DIM     = 256;
    localparam int FRAME_DEPTH = 65536;

    // Register field widths are fixed by the register map.
    localparam int REG_DIM_W = 9;
    localparam int ROT_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int COORD_W = $clog2(MAX_DIM);
    localparam int CNT_W   = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int ADDR_W  = $clog2(FRAME_DEPTH);
    localparam int SUM_W   = COORD_W + DIM_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Q16 luma weights for 0.299, 0.587 and 0.114.
    localparam int LUMA_W = 16;
    localparam int PROD_W = LUMA_W + 8;
    localparam logic [LUMA_W-1:0] LUMA_R = 16'd19595;
    localparam logic [LUMA_W-1:0] LUMA_G = 16'd38470;
    localparam logic [LUMA_W-1:0] LUMA_B = 16'd7471;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTATION = 3'd0,
        CFG_GREY     = 3'd1,
        CFG_INVERT   = 3'd2,
        CFG_WIDTH    = 3'd3,
        CFG_HEIGHT   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_FETCH,
        OP_NOFRAME
    } t_op;

    typedef struct packed {
        logic       cmd;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } t_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       last_pixel;
        logic       status;
    } t_out;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    // One classified item on its way from the front end to the store side.
    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic              in_range;
        t_pixel            pixel;
        logic              last;
        logic              grey;
        logic              invert;
    } t_entry;

endpackage

`default_nettype wire

// ----- rtl/frgi_ram.sv -----
// Generic single-port RAM with registered read data.
`default_nettype none

module frgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/frgi_front.sv -----
// Front end: registers, load and scan counters, rotated address generation.
`default_nettype none

module frgi_front
    import frgi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_start,
    input  wire t_in                   i_in,
    input  wire logic                  i_full,
    output logic                       o_busy,
    output logic                       o_push,
    output t_entry                     o_entry
);

    localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270 = 2'd3;
    localparam logic [REG_DIM_W-1:0] RESET_DIM = 9'd256;

    logic [ROT_W-1:0]     r_rotation;
    logic                 r_grey;
    logic                 r_invert;
    logic [REG_DIM_W-1:0] r_width;
    logic [REG_DIM_W-1:0] r_height;

    logic [CNT_W-1:0]     r_load_count, n_load_count;
    logic                 r_have_frame, n_have_frame;
    logic [COORD_W-1:0]   r_col, n_col;
    logic [COORD_W-1:0]   r_row, n_row;

    logic                 accept;
    logic [DIM_W-1:0]     w, h, dw, dh, x, y, col_inc;
    logic [COORD_W-1:0]   col, row;
    logic [CNT_W-1:0]     total, load_inc;
    logic [SUM_W-1:0]     addr_full;
    logic                 last;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [REG_DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > 32'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation <= ROT_0;
            r_grey     <= 1'b0;
            r_invert   <= 1'b0;
            r_width    <= RESET_DIM;
            r_height   <= RESET_DIM;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROTATION: r_rotation <= i_cfg_data[ROT_W-1:0];
                CFG_GREY:     r_grey     <= i_cfg_data[0];
                CFG_INVERT:   r_invert   <= i_cfg_data[0];
                CFG_WIDTH:    r_width    <= i_cfg_data[REG_DIM_W-1:0];
                CFG_HEIGHT:   r_height   <= i_cfg_data[REG_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept = i_start && !i_full;
    assign o_busy = i_full;

    always_comb begin
        w     = clamp_dim(r_width);
        h     = clamp_dim(r_height);
        total = CNT_W'(w) * CNT_W'(h);
        dw    = r_rotation[0] ? h : w;
        dh    = r_rotation[0] ? w : h;

        // A register change may leave the scan position outside the new frame.
        col = (DIM_W'(r_col) >= dw) ? COORD_W'(dw - DIM_W'(1)) : r_col;
        row = (DIM_W'(r_row) >= dh) ? COORD_W'(dh - DIM_W'(1)) : r_row;

        case (r_rotation)
            ROT_90: begin
                x = DIM_W'(row);
                y = h - DIM_W'(1) - DIM_W'(col);
            end
            ROT_180: begin
                x = w - DIM_W'(1) - DIM_W'(col);
                y = h - DIM_W'(1) - DIM_W'(row);
            end
            ROT_270: begin
                x = w - DIM_W'(1) - DIM_W'(row);
                y = DIM_W'(col);
            end
            default: begin
                x = DIM_W'(col);
                y = DIM_W'(row);
            end
        endcase

        addr_full = SUM_W'(COORD_W'(y)) * SUM_W'(w) + SUM_W'(COORD_W'(x));
        last      = (DIM_W'(col) == dw - DIM_W'(1)) && (DIM_W'(row) == dh - DIM_W'(1));
        col_inc   = DIM_W'(col) + DIM_W'(1);
        load_inc  = r_load_count + CNT_W'(1);

        n_load_count = r_load_count;
        n_have_frame = r_have_frame;
        n_col        = r_col;
        n_row        = r_row;
        o_push       = 1'b0;

        o_entry.op       = OP_LOAD;
        o_entry.addr     = ADDR_W'(r_load_count);
        o_entry.in_range = 64'(r_load_count) < 64'(FRAME_DEPTH);
        o_entry.pixel    = '{alpha: i_in.alpha_in, blue: i_in.blue_in,
                             green: i_in.green_in, red: i_in.red_in};
        o_entry.last     = last;
        o_entry.grey     = r_grey;
        o_entry.invert   = r_invert;

        if (accept) begin
            if (!i_in.cmd) begin
                // Loads arriving while a frame is held are dropped here.
                if (!r_have_frame) begin
                    o_push       = 1'b1;
                    n_load_count = load_inc;
                    if (load_inc >= total) begin
                        n_have_frame = 1'b1;
                    end
                end
            end else if (!r_have_frame) begin
                o_push     = 1'b1;
                o_entry.op = OP_NOFRAME;
            end else begin
                o_push           = 1'b1;
                o_entry.op       = OP_FETCH;
                o_entry.addr     = ADDR_W'(addr_full);
                o_entry.in_range = 64'(addr_full) < 64'(FRAME_DEPTH);
                if (last) begin
                    n_col        = '0;
                    n_row        = '0;
                    n_have_frame = 1'b0;
                    n_load_count = '0;
                end else if (col_inc >= dw) begin
                    n_col = '0;
                    n_row = row + COORD_W'(1);
                end else begin
                    n_col = COORD_W'(col_inc);
                    n_row = row;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
            r_have_frame <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
        end else begin
            r_load_count <= n_load_count;
            r_have_frame <= n_have_frame;
            r_col        <= n_col;
            r_row        <= n_row;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/frgi_queue.sv -----
// Short FIFO of classified items between the front end and the store side.
`default_nettype none

module frgi_queue
    import frgi_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output t_entry      o_entry,
    output logic        o_empty,
    output logic        o_full
);

    t_entry              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/frgi_back.sv -----
// Store side: frame store access, luma conversion, inversion and result register.
`default_nettype none

module frgi_back
    import frgi_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_entry i_entry,
    input  wire logic   i_empty,
    output logic        o_pop,
    output logic        o_done,
    output t_out        o_out
);

    logic               ram_we;
    logic [31:0]        ram_rdata;

    logic               r_s1_valid;
    logic               r_s1_nofr;
    logic               r_s1_in_range;
    logic               r_s1_last;
    logic               r_s1_grey;
    logic               r_s1_invert;
    t_pixel             s1_px;

    logic               r_s2_valid;
    logic               r_s2_nofr;
    logic               r_s2_last;
    logic               r_s2_grey;
    logic               r_s2_invert;
    t_pixel             r_s2_px;
    logic [PROD_W-1:0]  r_s2_pr_r;
    logic [PROD_W-1:0]  r_s2_pr_g;
    logic [PROD_W-1:0]  r_s2_pr_b;

    logic [PROD_W:0]    luma_sum;
    logic [7:0]         luma;
    t_out               n_out;

    // The store side never stalls, so the queue drains one beat a cycle.
    assign o_pop  = !i_empty;
    assign ram_we = o_pop && (i_entry.op == OP_LOAD) && i_entry.in_range;

    frgi_ram #(
        .WIDTH (32),
        .DEPTH (FRAME_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (i_entry.addr),
        .i_wdata (i_entry.pixel),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_pop && (i_entry.op != OP_LOAD);
        end
        r_s1_nofr     <= (i_entry.op == OP_NOFRAME);
        r_s1_in_range <= i_entry.in_range;
        r_s1_last     <= i_entry.last;
        r_s1_grey     <= i_entry.grey;
        r_s1_invert   <= i_entry.invert;
    end

    assign s1_px = (r_s1_nofr || !r_s1_in_range) ? '0 : t_pixel'(ram_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_nofr   <= r_s1_nofr;
        r_s2_last   <= r_s1_last;
        r_s2_grey   <= r_s1_grey;
        r_s2_invert <= r_s1_invert;
        r_s2_px     <= s1_px;
        r_s2_pr_r   <= PROD_W'(LUMA_R) * PROD_W'(s1_px.red);
        r_s2_pr_g   <= PROD_W'(LUMA_G) * PROD_W'(s1_px.green);
        r_s2_pr_b   <= PROD_W'(LUMA_B) * PROD_W'(s1_px.blue);
    end

    always_comb begin
        luma_sum = (PROD_W + 1)'(r_s2_pr_r) + (PROD_W + 1)'(r_s2_pr_g)
                 + (PROD_W + 1)'(r_s2_pr_b);
        // The weights sum to one in Q16, so the luma never exceeds eight bits.
        luma     = luma_sum[LUMA_W +: 8];

        n_out.red_out    = r_s2_grey ? luma : r_s2_px.red;
        n_out.green_out  = r_s2_grey ? luma : r_s2_px.green;
        n_out.blue_out   = r_s2_grey ? luma : r_s2_px.blue;
        n_out.alpha_out  = r_s2_px.alpha;
        n_out.last_pixel = r_s2_last;
        n_out.status     = 1'b0;
        if (r_s2_invert) begin
            n_out.red_out   = ~n_out.red_out;
            n_out.green_out = ~n_out.green_out;
            n_out.blue_out  = ~n_out.blue_out;
        end
        // A fetch without a stored frame reports status only.
        if (r_s2_nofr) begin
            n_out        = '0;
            n_out.status = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_s2_valid;
        end
        o_out <= n_out;
    end

endmodule

`default_nettype wire

// ----- rtl/frame_rotate_grey_invert.sv -----
// Top level of the RGBA8 frame rotation engine with greyscale and inversion.
//
// The block takes one beat per clock: a load writes the next source pixel into the
// 65536 x 32 frame store, a fetch reads the next destination pixel in rotated raster
// order. Each beat uses the single frame-store port once, which sets the rate of one
// item per cycle. A fetch result appears on o_out with o_done high for one cycle, after the
// beat passes the queue, the store read, the luma products and the result register; a
// load gives no result. Results cannot be held off. busy rises only if the four-entry
// queue between the front end and the store side is full. Configuration writes are
// always ready and must be made while no fetch result is outstanding.
`default_nettype none

module frame_rotate_grey_invert
    import frgi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_in                   i_in,
    output logic                       o_done,
    output t_out                       o_out
);

    logic   push;
    logic   pop;
    logic   q_empty;
    logic   q_full;
    t_entry front_entry;
    t_entry head_entry;

    assign o_cfg_ready = 1'b1;

    frgi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_start     (start),
        .i_in        (i_in),
        .i_full      (q_full),
        .o_busy      (busy),
        .o_push      (push),
        .o_entry     (front_entry)
    );

    frgi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    frgi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (head_entry),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_done  (o_done),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
